// File: design/bjtd_pkg.sv
// Shared types and constants of the binary JSON token decoder.
`default_nettype none

package bjtd_pkg;

    localparam int LEVEL_W = 7;
    localparam int LIMIT_W = 7;
    localparam logic [LIMIT_W-1:0] NEST_LIMIT_RST = 7'd64;

    // Tag bytes of the input chunk.
    localparam logic [7:0] TAG_OBJ_OPEN  = 8'd1;
    localparam logic [7:0] TAG_OBJ_CLOSE = 8'd2;
    localparam logic [7:0] TAG_ARR_OPEN  = 8'd3;
    localparam logic [7:0] TAG_ARR_CLOSE = 8'd4;
    localparam logic [7:0] TAG_COLON     = 8'd5;
    localparam logic [7:0] TAG_COMMA     = 8'd6;
    localparam logic [7:0] TAG_STRING    = 8'd8;
    localparam logic [7:0] TAG_INT64     = 8'd10;
    localparam logic [7:0] TAG_REAL      = 8'd18;
    localparam logic [7:0] TAG_NULL      = 8'd23;
    localparam logic [7:0] TAG_TRUE      = 8'd24;
    localparam logic [7:0] TAG_FALSE     = 8'd25;

    // Event codes of a result.
    localparam logic [3:0] EV_NULL       = 4'd0;
    localparam logic [3:0] EV_FALSE      = 4'd1;
    localparam logic [3:0] EV_TRUE       = 4'd2;
    localparam logic [3:0] EV_INT64      = 4'd3;
    localparam logic [3:0] EV_REAL_BEGIN = 4'd4;
    localparam logic [3:0] EV_REAL_BYTE  = 4'd5;
    localparam logic [3:0] EV_STR_BEGIN  = 4'd6;
    localparam logic [3:0] EV_STR_BYTE   = 4'd7;
    localparam logic [3:0] EV_ARR_OPEN   = 4'd8;
    localparam logic [3:0] EV_ARR_CLOSE  = 4'd9;
    localparam logic [3:0] EV_OBJ_OPEN   = 4'd10;
    localparam logic [3:0] EV_OBJ_CLOSE  = 4'd11;
    localparam logic [3:0] EV_END        = 4'd12;

    // Status codes carried by the end event.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_CORRUPT = 2'd1;
    localparam logic [1:0] ST_LIMIT   = 2'd2;

    // Container stack entry.
    typedef enum logic [1:0] {
        ENT_ARRAY = 2'd0,
        ENT_KEY   = 2'd1,
        ENT_COLON = 2'd2,
        ENT_VALUE = 2'd3
    } entry_t;

    typedef enum logic [4:0] {
        PH_TOP  = 5'b00001,
        PH_CONT = 5'b00010,
        PH_LEN  = 5'b00100,
        PH_INT  = 5'b01000,
        PH_PAY  = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       chunk_end;
    } in_item_t;

    typedef struct packed {
        logic [3:0]         event_res;
        logic [63:0]        value;
        logic [LEVEL_W-1:0] level;
        logic               is_key;
        logic [1:0]         status;
        logic               final_res;
    } res_item_t;

    typedef struct packed {
        logic [1:0] cnt;
        res_item_t  r0;
        res_item_t  r1;
    } res_pair_t;

endpackage

`default_nettype wire

// File: design/bjtd_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none

module bjtd_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// File: design/bjtd_core.sv
// Decode logic: parser state, container stack and result generation.
`default_nettype none

module bjtd_core import bjtd_pkg::*; #(
    parameter int MAX_DEPTH = 64
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               step,
    input  wire in_item_t           item,
    input  wire logic [LIMIT_W-1:0] nest_limit,
    output res_pair_t               res
);

    localparam int DW = $clog2(MAX_DEPTH + 1);
    localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int CW = (DW > LIMIT_W) ? DW : LIMIT_W;

    phase_t          phase_reg, phase_next;
    logic            finished_reg, finished_next;
    logic [DW-1:0]   depth_reg, depth_next;
    logic [DW-1:0]   keycnt_reg, keycnt_next;
    entry_t          top_reg, top_next;
    entry_t          sec_reg, sec_next;
    logic [31:0]     pay_reg, pay_next;
    logic [3:0]      len_reg, len_next;
    logic            kind_real_reg, kind_real_next;
    logic [63:0]     acc_reg, acc_next;
    logic            byp_valid_reg, byp_valid_next;
    logic [1:0]      byp_data_reg;

    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic [1:0]      wr_data;
    logic [AW-1:0]   rd_addr;
    logic [1:0]      rd_data;
    entry_t          mem_below;

    logic [DW-1:0]   dm2, dm3;
    logic [7:0]      b;
    logic            last;
    logic            cur_key;
    logic            lim_hit;

    logic            prim_v;
    logic [3:0]      prim_ev;
    logic [63:0]     prim_val;
    logic [DW-1:0]   prim_lvl;
    logic            prim_key;
    logic            end_v;
    logic [1:0]      end_st;
    logic [DW-1:0]   end_lvl;
    logic            do_start;
    logic            do_vd;
    logic            ok;
    res_item_t       prim_res, end_res;

    assign b         = item.data_byte;
    assign last      = item.chunk_end;
    assign cur_key   = (depth_reg != '0) && (top_reg == ENT_KEY);
    assign lim_hit   = (CW'(depth_reg) >= CW'(nest_limit)) || (depth_reg >= DW'(MAX_DEPTH));
    assign dm2       = depth_reg - DW'(2);
    assign mem_below = entry_t'(byp_valid_reg ? byp_data_reg : rd_data);

    always_comb begin
        phase_next     = phase_reg;
        finished_next  = finished_reg;
        depth_next     = depth_reg;
        keycnt_next    = keycnt_reg;
        top_next       = top_reg;
        sec_next       = sec_reg;
        pay_next       = pay_reg;
        len_next       = len_reg;
        kind_real_next = kind_real_reg;
        acc_next       = acc_reg;
        wr_en          = 1'b0;
        wr_addr        = dm2[AW-1:0];
        wr_data        = sec_reg;
        prim_v         = 1'b0;
        prim_ev        = EV_NULL;
        prim_val       = '0;
        prim_lvl       = depth_reg;
        prim_key       = cur_key;
        end_v          = 1'b0;
        end_st         = ST_OK;
        end_lvl        = '0;
        do_start       = 1'b0;
        do_vd          = 1'b0;
        ok             = 1'b0;

        if (step) begin
            if (finished_reg) begin
                if (last) begin
                    phase_next    = PH_TOP;
                    finished_next = 1'b0;
                    depth_next    = '0;
                    keycnt_next   = '0;
                    pay_next      = '0;
                    len_next      = '0;
                    kind_real_next = 1'b0;
                    acc_next      = '0;
                end
            end else begin
                case (phase_reg)
                    PH_TOP: begin
                        do_start = 1'b1;
                    end
                    PH_CONT: begin
                        case (top_reg)
                            ENT_COLON: begin
                                if (b == TAG_COLON) begin
                                    top_next = ENT_VALUE;
                                end else begin
                                    end_v         = 1'b1;
                                    end_st        = ST_CORRUPT;
                                    end_lvl       = depth_reg;
                                    finished_next = 1'b1;
                                end
                            end
                            ENT_ARRAY, ENT_KEY: begin
                                if (b == TAG_COMMA) begin
                                    // Separators carry no information.
                                end else if ((top_reg == ENT_ARRAY && b == TAG_ARR_CLOSE) ||
                                             (top_reg == ENT_KEY && b == TAG_OBJ_CLOSE)) begin
                                    depth_next = depth_reg - DW'(1);
                                    top_next   = sec_reg;
                                    sec_next   = mem_below;
                                    if (depth_next != '0 && sec_reg == ENT_KEY) begin
                                        keycnt_next = keycnt_reg - DW'(1);
                                    end
                                    prim_v   = 1'b1;
                                    prim_ev  = (top_reg == ENT_ARRAY) ? EV_ARR_CLOSE
                                                                      : EV_OBJ_CLOSE;
                                    prim_lvl = depth_next;
                                    prim_key = (depth_next != '0) && (sec_reg == ENT_KEY);
                                    do_vd    = 1'b1;
                                end else begin
                                    do_start = 1'b1;
                                end
                            end
                            default: begin
                                do_start = 1'b1;
                            end
                        endcase
                    end
                    PH_LEN: begin
                        pay_next = {pay_reg[23:0], b};
                        if (len_reg != '0) begin
                            len_next = len_reg - 4'd1;
                        end
                        if (len_next == '0) begin
                            prim_v   = 1'b1;
                            prim_ev  = kind_real_reg ? EV_REAL_BEGIN : EV_STR_BEGIN;
                            prim_val = {32'd0, pay_next};
                            if (pay_next == '0) begin
                                do_vd = 1'b1;
                            end else begin
                                phase_next = PH_PAY;
                            end
                        end
                    end
                    PH_INT: begin
                        acc_next = {acc_reg[55:0], b};
                        if (len_reg != '0) begin
                            len_next = len_reg - 4'd1;
                        end
                        if (len_next == '0) begin
                            prim_v   = 1'b1;
                            prim_ev  = EV_INT64;
                            prim_val = acc_next;
                            do_vd    = 1'b1;
                        end
                    end
                    PH_PAY: begin
                        prim_v   = 1'b1;
                        prim_ev  = kind_real_reg ? EV_REAL_BYTE : EV_STR_BYTE;
                        prim_val = {56'd0, b};
                        if (pay_reg != '0) begin
                            pay_next = pay_reg - 32'd1;
                        end
                        if (pay_next == '0) begin
                            do_vd = 1'b1;
                        end
                    end
                    default: begin
                        end_v         = 1'b1;
                        end_st        = ST_CORRUPT;
                        end_lvl       = depth_reg;
                        finished_next = 1'b1;
                    end
                endcase

                if (do_start) begin
                    if (lim_hit) begin
                        end_v         = 1'b1;
                        end_st        = ST_LIMIT;
                        end_lvl       = depth_reg;
                        finished_next = 1'b1;
                    end else begin
                        case (b)
                            TAG_NULL, TAG_FALSE, TAG_TRUE: begin
                                prim_v  = 1'b1;
                                prim_ev = (b == TAG_NULL)  ? EV_NULL :
                                          (b == TAG_FALSE) ? EV_FALSE : EV_TRUE;
                                do_vd   = 1'b1;
                            end
                            TAG_INT64: begin
                                phase_next = PH_INT;
                                len_next   = 4'd8;
                                acc_next   = '0;
                            end
                            TAG_REAL: begin
                                phase_next     = PH_LEN;
                                len_next       = 4'd2;
                                kind_real_next = 1'b1;
                                pay_next       = '0;
                            end
                            TAG_STRING: begin
                                phase_next     = PH_LEN;
                                len_next       = 4'd4;
                                kind_real_next = 1'b0;
                                pay_next       = '0;
                            end
                            TAG_ARR_OPEN, TAG_OBJ_OPEN: begin
                                prim_v     = 1'b1;
                                prim_ev    = (b == TAG_ARR_OPEN) ? EV_ARR_OPEN : EV_OBJ_OPEN;
                                depth_next = depth_reg + DW'(1);
                                top_next   = (b == TAG_ARR_OPEN) ? ENT_ARRAY : ENT_KEY;
                                sec_next   = top_reg;
                                if (depth_reg >= DW'(2)) begin
                                    wr_en = 1'b1;
                                end
                                if (cur_key) begin
                                    keycnt_next = keycnt_reg + DW'(1);
                                end
                                phase_next = PH_CONT;
                            end
                            default: begin
                                end_v         = 1'b1;
                                end_st        = ST_CORRUPT;
                                end_lvl       = depth_reg;
                                finished_next = 1'b1;
                            end
                        endcase
                    end
                end

                if (do_vd) begin
                    if (depth_next == '0) begin
                        end_v         = 1'b1;
                        end_st        = ST_OK;
                        end_lvl       = '0;
                        finished_next = 1'b1;
                    end else begin
                        if (top_next == ENT_KEY) begin
                            top_next = ENT_COLON;
                        end else if (top_next == ENT_VALUE) begin
                            top_next = ENT_KEY;
                        end
                        phase_next = PH_CONT;
                    end
                end

                if (last) begin
                    if (!finished_next) begin
                        // Open containers may close silently, but only if no level
                        // is halfway through a key or a key/value pair.
                        ok = (phase_next == PH_CONT) &&
                             (top_next == ENT_ARRAY || top_next == ENT_KEY) &&
                             (keycnt_next == '0);
                        end_v   = 1'b1;
                        end_st  = ok ? ST_OK : ST_CORRUPT;
                        end_lvl = ok ? '0 : depth_next;
                    end
                    phase_next     = PH_TOP;
                    finished_next  = 1'b0;
                    depth_next     = '0;
                    keycnt_next    = '0;
                    pay_next       = '0;
                    len_next       = '0;
                    kind_real_next = 1'b0;
                    acc_next       = '0;
                end
            end
        end
    end

    assign dm3            = depth_next - DW'(3);
    assign rd_addr        = dm3[AW-1:0];
    assign byp_valid_next = wr_en && (wr_addr == rd_addr);

    always_comb begin
        prim_res.event_res = prim_ev;
        prim_res.value     = prim_val;
        prim_res.level     = LEVEL_W'(prim_lvl);
        prim_res.is_key    = prim_key;
        prim_res.status    = ST_OK;
        prim_res.final_res = 1'b0;
        end_res.event_res  = EV_END;
        end_res.value      = '0;
        end_res.level      = LEVEL_W'(end_lvl);
        end_res.is_key     = 1'b0;
        end_res.status     = end_st;
        end_res.final_res  = 1'b1;
        res.cnt            = 2'(prim_v) + 2'(end_v);
        res.r0             = prim_v ? prim_res : end_res;
        res.r1             = end_res;
    end

    bjtd_ram #(
        .WIDTH (2),
        .DEPTH (MAX_DEPTH)
    ) u_stack_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_TOP;
            finished_reg  <= 1'b0;
            depth_reg     <= '0;
            keycnt_reg    <= '0;
            byp_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            finished_reg  <= finished_next;
            depth_reg     <= depth_next;
            keycnt_reg    <= keycnt_next;
            byp_valid_reg <= byp_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        top_reg       <= top_next;
        sec_reg       <= sec_next;
        pay_reg       <= pay_next;
        len_reg       <= len_next;
        kind_real_reg <= kind_real_next;
        acc_reg       <= acc_next;
        byp_data_reg  <= wr_data;
    end

    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= DW'(MAX_DEPTH))
        else $error("stack depth beyond its maximum");

    a_keycnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        keycnt_reg <= depth_reg)
        else $error("key container count exceeds depth");

    a_idle_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !step |=> $stable(depth_reg) && $stable(phase_reg) && $stable(finished_reg))
        else $error("decoder state moved without a transaction");

endmodule

`default_nettype wire

// File: design/bjtd_out_fifo.sv
// Four-entry result queue that takes up to two results per cycle.
`default_nettype none

module bjtd_out_fifo import bjtd_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire res_pair_t wr,
    output logic           room,
    output logic           m_valid,
    input  wire logic      m_ready,
    output res_item_t      m_data
);

    res_item_t  mem [4];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg, count_next;
    logic       pop;

    assign m_valid = (count_reg != 3'd0);
    assign m_data  = mem[rd_ptr_reg];
    assign pop     = m_valid && m_ready;
    // Two free entries guarantee that any transaction's results fit.
    assign room    = (count_reg <= 3'd2);

    assign wr_ptr_next = wr_ptr_reg + wr.cnt;
    assign rd_ptr_next = rd_ptr_reg + 2'(pop);
    assign count_next  = count_reg + 3'(wr.cnt) - 3'(pop);

    always_ff @(posedge aclk) begin
        if (wr.cnt != 2'd0) begin
            mem[wr_ptr_reg] <= wr.r0;
        end
        if (wr.cnt == 2'd2) begin
            mem[wr_ptr_reg + 2'd1] <= wr.r1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr.cnt != 2'd0) |-> (3'(wr.cnt) + count_reg <= 3'd4))
        else $error("result queue overflow");

endmodule

`default_nettype wire

// File: design/binary_json_token_decoder.sv
// Top level of the binary JSON token decoder: input register, config and result queue.
// A byte accepted into the input register is decoded once the result queue has room,
// and its results are written to the queue, which drives m_valid from its registers.
// Throughput: one byte per cycle while the result side takes one result per cycle;
// bytes that produce two results are paced by the one-result-per-cycle output port.
// Reset (aresetn, synchronous, active low) re-arms the parser, empties the result queue
// and sets nest_limit to 64; the container stack RAM is not cleared.
`default_nettype none

module binary_json_token_decoder import bjtd_pkg::*; #(
    parameter int MAX_DEPTH = 64
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic [LIMIT_W-1:0] cfg_wr_data,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire in_item_t           s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output res_item_t               m_data
);

    // The input register holds one byte until the result queue can take
    // everything that byte may produce. The decoder then updates its state
    // and writes the results in the same cycle.
    logic               in_valid_reg, in_valid_next;
    in_item_t           in_data_reg;
    logic [LIMIT_W-1:0] nest_limit_reg;
    logic               room;
    logic               step;
    logic               s_fire;
    res_pair_t          results;

    assign step    = in_valid_reg && room;
    // Ready comes from registers only, so no combinational path runs from m_ready.
    assign s_ready = !in_valid_reg || step;
    assign s_fire  = s_valid && s_ready;

    always_comb begin
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (step) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            nest_limit_reg <= NEST_LIMIT_RST;
        end else begin
            in_valid_reg <= in_valid_next;
            if (cfg_wr_en) begin
                nest_limit_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_data_reg <= s_data;
        end
    end

    bjtd_core #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (step),
        .item       (in_data_reg),
        .nest_limit (nest_limit_reg),
        .res        (results)
    );

    bjtd_out_fifo u_out_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (results),
        .room    (room),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // A transaction that ends a decode must deliver its end event; the core
    // must therefore never report results in a cycle that decodes no transaction.
    a_results_need_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (results.cnt != 2'd0) |-> step)
        else $error("results produced without a decoded transaction");

endmodule

`default_nettype wire
